FILE: hdl/hrhp_pkg.sv
`timescale 1ns / 1ps

package hrhp_pkg;

    localparam int COUNT_BITS_DEF = 31;
    localparam int BODY_LEN_W     = 31;
    localparam int KW_LEN         = 14;

    localparam logic [15:0] HDR_LIMIT_RST = 16'd8192;
    localparam logic [15:0] HDR_COUNT_MAX = 16'hFFFF;
    localparam logic [9:0]  STATUS_OK     = 10'd200;
    localparam logic [9:0]  STATUS_SAT    = 10'd1023;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // terminator matcher progress through CR LF CR LF
    localparam logic [1:0] TM_NONE   = 2'd0;
    localparam logic [1:0] TM_CR     = 2'd1;
    localparam logic [1:0] TM_CRLF   = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_HDR_LONG   = 3'd1,
        ERR_BAD_STATUS = 3'd2,
        ERR_NOT_200    = 3'd3,
        ERR_NO_LENGTH  = 3'd4,
        ERR_BAD_LENGTH = 3'd5
    } err_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_ERROR  = 4'b1000
    } phase_t;

    typedef enum logic [6:0] {
        ST_BEFORE   = 7'b0000001,
        ST_AFTER_SP = 7'b0000010,
        ST_SP_CR    = 7'b0000100,
        ST_SKIP     = 7'b0001000,
        ST_DIGITS   = 7'b0010000,
        ST_FINISHED = 7'b0100000,
        ST_BAD      = 7'b1000000
    } status_state_t;

    typedef enum logic [4:0] {
        LS_SEARCH = 5'b00001,
        LS_SKIP   = 5'b00010,
        LS_DIGITS = 5'b00100,
        LS_DONE   = 5'b01000,
        LS_BAD    = 5'b10000
    } len_state_t;

    typedef struct packed {
        logic adv;    // item moves from input stage to result stage
        logic first;  // item starts a new response
        logic hdr;    // item belongs to the header
    } step_ctrl_t;

    typedef struct packed {
        logic bad;      // no usable status code
        logic not_200;
    } status_flags_t;

    typedef struct packed {
        logic found;
        logic bad;
    } length_flags_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43;  // C
            4'd1:    c = 8'h6F;  // o
            4'd2:    c = 8'h6E;  // n
            4'd3:    c = 8'h74;  // t
            4'd4:    c = 8'h65;  // e
            4'd5:    c = 8'h6E;  // n
            4'd6:    c = 8'h74;  // t
            4'd7:    c = 8'h2D;  // -
            4'd8:    c = 8'h4C;  // L
            4'd9:    c = 8'h65;  // e
            4'd10:   c = 8'h6E;  // n
            4'd11:   c = 8'h67;  // g
            4'd12:   c = 8'h74;  // t
            4'd13:   c = 8'h68;  // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/hrhp_status.sv
`timescale 1ns / 1ps

module hrhp_status (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hrhp_pkg::step_ctrl_t   ctrl,
    input  logic [7:0]             data_byte,
    input  logic                   crlf,
    output hrhp_pkg::status_flags_t flags
);

    hrhp_pkg::status_state_t state_reg, state_cur, state_next;
    logic [9:0]  value_reg, value_cur, value_next;
    logic [13:0] value_acc;
    logic [9:0]  value_digit;
    logic [9:0]  first_digit;
    logic        blank;
    logic        digit;

    assign state_cur = ctrl.first ? hrhp_pkg::ST_BEFORE : state_reg;
    assign value_cur = ctrl.first ? 10'd0 : value_reg;

    assign blank = (data_byte == hrhp_pkg::CH_SP) || (data_byte == hrhp_pkg::CH_TAB);
    assign digit = hrhp_pkg::is_digit(data_byte);

    assign first_digit = 10'(data_byte - hrhp_pkg::CH_ZERO);
    assign value_acc   = {value_cur, 3'b000} + {3'b000, value_cur, 1'b0}
                       + 14'(data_byte - hrhp_pkg::CH_ZERO);
    // saturate the code at ten bits
    assign value_digit = (value_acc > 14'(hrhp_pkg::STATUS_SAT)) ? hrhp_pkg::STATUS_SAT
                                                                 : value_acc[9:0];

    always_comb begin
        state_next = state_cur;
        value_next = value_cur;
        if (ctrl.hdr) begin
            unique case (state_cur)
                hrhp_pkg::ST_BEFORE: begin
                    if (crlf) begin
                        state_next = hrhp_pkg::ST_BAD;
                    end else if (data_byte == hrhp_pkg::CH_SP) begin
                        state_next = hrhp_pkg::ST_AFTER_SP;
                    end
                end
                hrhp_pkg::ST_AFTER_SP: begin
                    if (data_byte == hrhp_pkg::CH_CR) begin
                        state_next = hrhp_pkg::ST_SP_CR;
                    end else if (blank) begin
                        state_next = hrhp_pkg::ST_SKIP;
                    end else if (digit) begin
                        value_next = first_digit;
                        state_next = hrhp_pkg::ST_DIGITS;
                    end else begin
                        state_next = hrhp_pkg::ST_FINISHED;
                    end
                end
                hrhp_pkg::ST_SP_CR: begin
                    state_next = (data_byte == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_BAD
                                                                : hrhp_pkg::ST_FINISHED;
                end
                hrhp_pkg::ST_SKIP: begin
                    if (digit) begin
                        value_next = first_digit;
                        state_next = hrhp_pkg::ST_DIGITS;
                    end else if (!blank) begin
                        state_next = hrhp_pkg::ST_FINISHED;
                    end
                end
                hrhp_pkg::ST_DIGITS: begin
                    if (digit) begin
                        value_next = value_digit;
                    end else begin
                        state_next = hrhp_pkg::ST_FINISHED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign flags.bad     = (state_next != hrhp_pkg::ST_DIGITS)
                        && (state_next != hrhp_pkg::ST_FINISHED);
    assign flags.not_200 = (value_next != hrhp_pkg::STATUS_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrhp_pkg::ST_BEFORE;
            value_reg <= 10'd0;
        end else if (ctrl.adv) begin
            state_reg <= state_next;
            value_reg <= value_next;
        end
    end

endmodule

FILE: hdl/hrhp_length.sv
`timescale 1ns / 1ps

module hrhp_length #(
    parameter int COUNT_BITS = hrhp_pkg::COUNT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hrhp_pkg::step_ctrl_t    ctrl,
    input  logic [7:0]              data_byte,
    output hrhp_pkg::length_flags_t flags,
    output logic [COUNT_BITS-1:0]   value_next
);

    localparam int VW = COUNT_BITS + 4;
    localparam logic [VW-1:0] LEN_MAX = VW'((64'd1 << COUNT_BITS) - 64'd2);

    hrhp_pkg::len_state_t state_reg, state_cur, state_next;
    logic [COUNT_BITS-1:0] value_reg, value_cur;
    logic [3:0]  idx_reg, idx_cur, idx_next, idx_inc;
    logic [VW-1:0] value_acc;
    logic [7:0]  digit_val;

    assign state_cur = ctrl.first ? hrhp_pkg::LS_SEARCH : state_reg;
    assign value_cur = ctrl.first ? '0 : value_reg;
    assign idx_cur   = ctrl.first ? 4'd0 : idx_reg;

    assign digit_val = data_byte - hrhp_pkg::CH_ZERO;
    assign idx_inc   = idx_cur + 4'd1;
    assign value_acc = VW'({value_cur, 3'b000}) + VW'({value_cur, 1'b0}) + VW'(digit_val[3:0]);

    always_comb begin
        state_next = state_cur;
        value_next = value_cur;
        idx_next   = idx_cur;
        if (ctrl.hdr) begin
            unique case (state_cur)
                hrhp_pkg::LS_SEARCH: begin
                    if (data_byte == hrhp_pkg::kw_char(idx_cur)) begin
                        idx_next = idx_inc;
                        if (idx_inc == 4'(hrhp_pkg::KW_LEN)) begin
                            state_next = hrhp_pkg::LS_SKIP;
                        end
                    end else begin
                        // restart on a fresh leading letter
                        idx_next = (data_byte == hrhp_pkg::kw_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                hrhp_pkg::LS_SKIP: begin
                    if ((data_byte == hrhp_pkg::CH_SP) || (data_byte == hrhp_pkg::CH_COLON)
                        || (data_byte == hrhp_pkg::CH_TAB)) begin
                        state_next = hrhp_pkg::LS_SKIP;
                    end else if (data_byte == hrhp_pkg::CH_MINUS) begin
                        state_next = hrhp_pkg::LS_BAD;
                    end else if (hrhp_pkg::is_digit(data_byte)) begin
                        value_next = COUNT_BITS'(digit_val[3:0]);
                        state_next = hrhp_pkg::LS_DIGITS;
                    end else begin
                        value_next = '0;
                        state_next = hrhp_pkg::LS_DONE;
                    end
                end
                hrhp_pkg::LS_DIGITS: begin
                    if (hrhp_pkg::is_digit(data_byte)) begin
                        if (value_acc > LEN_MAX) begin
                            state_next = hrhp_pkg::LS_BAD;
                        end else begin
                            value_next = value_acc[COUNT_BITS-1:0];
                        end
                    end else begin
                        state_next = hrhp_pkg::LS_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign flags.found = (state_next != hrhp_pkg::LS_SEARCH);
    assign flags.bad   = (state_next == hrhp_pkg::LS_BAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrhp_pkg::LS_SEARCH;
            value_reg <= '0;
            idx_reg   <= 4'd0;
        end else if (ctrl.adv) begin
            state_reg <= state_next;
            value_reg <= value_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: hdl/http_response_header_parser_top.sv
`timescale 1ns / 1ps

// HTTP response parser: checks the status line for code 200, reads the first
// Content-Length value, finds the blank line that ends the header and then
// passes the body bytes on until the given length is reached.
// Input stream: one response byte per transaction; tuser[0] marks the first
// byte of a new response and clears all parse state before that byte.
// Output stream: exactly one transaction per input byte carrying the body
// byte (when passed on), header done, response done (tlast), an error code
// and the parsed body length.
// cfg_wr_en/cfg_wr_data write the header byte limit; write only while idle.
// Each input transaction is held in the input register, then goes through the
// status, length and phase update into the result register. One byte per
// cycle is sustained while the receiver takes each result; the per-byte update
// of the phase, terminator and counters is combinational between those registers.
// Reset clears the parse state and sets the header limit to 8192. While the
// receiver stalls the result register holds; one more byte waits in the input
// register, then s_tready drops until the result is taken.
module http_response_header_parser_top #(
    parameter int COUNT_BITS = hrhp_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // header_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic [0:0]  s_tuser,       // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [7:0] body_byte, [38:8] content_len, [39] zero
    output logic [4:0]  m_tuser,       // [0] body_valid, [1] header_done, [4:2] error_code
    output logic        m_tlast        // response_done
);

    logic [15:0] hdr_limit_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       adv;

    hrhp_pkg::phase_t phase_reg, phase_cur, phase_next;
    logic [1:0]  term_reg, term_cur, term_next;
    logic [15:0] hcnt_reg, hcnt_cur, hcnt_next;
    logic [COUNT_BITS-1:0] body_cnt_reg, body_cnt_cur, body_cnt_next, body_cnt_inc;

    hrhp_pkg::step_ctrl_t    ctrl;
    hrhp_pkg::status_flags_t st_flags;
    hrhp_pkg::length_flags_t len_flags;
    logic [COUNT_BITS-1:0]   len_value;

    logic crlf;
    logic complete;
    hrhp_pkg::err_t err_next;
    logic body_valid_next, header_done_next, resp_done_next;
    logic [7:0] body_byte_next;

    logic        out_valid_reg;
    logic        body_valid_reg, header_done_reg, resp_done_reg;
    logic [7:0]  body_byte_reg;
    logic [2:0]  err_reg;
    logic [hrhp_pkg::BODY_LEN_W-1:0] body_len_reg, body_len_next;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_limit_reg <= hrhp_pkg::HDR_LIMIT_RST;
        end else if (cfg_wr_en) begin
            hdr_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    // state as seen after an optional start-of-response clear
    assign phase_cur    = in_first_reg ? hrhp_pkg::PH_HEADER : phase_reg;
    assign term_cur     = in_first_reg ? hrhp_pkg::TM_NONE : term_reg;
    assign hcnt_cur     = in_first_reg ? 16'd0 : hcnt_reg;
    assign body_cnt_cur = in_first_reg ? '0 : body_cnt_reg;

    assign ctrl.adv   = adv;
    assign ctrl.first = in_first_reg;
    assign ctrl.hdr   = (phase_cur == hrhp_pkg::PH_HEADER);

    assign crlf     = (in_byte_reg == hrhp_pkg::CH_LF)
                   && ((term_cur == hrhp_pkg::TM_CR) || (term_cur == hrhp_pkg::TM_CRLFCR));
    assign complete = (in_byte_reg == hrhp_pkg::CH_LF) && (term_cur == hrhp_pkg::TM_CRLFCR);

    hrhp_status u_status (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .data_byte (in_byte_reg),
        .crlf      (crlf),
        .flags     (st_flags)
    );

    hrhp_length #(
        .COUNT_BITS (COUNT_BITS)
    ) u_length (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .data_byte  (in_byte_reg),
        .flags      (len_flags),
        .value_next (len_value)
    );

    assign body_cnt_inc = body_cnt_cur + 1'b1;

    always_comb begin
        phase_next       = phase_cur;
        term_next        = term_cur;
        hcnt_next        = hcnt_cur;
        body_cnt_next    = body_cnt_cur;
        err_next         = hrhp_pkg::ERR_NONE;
        body_valid_next  = 1'b0;
        body_byte_next   = 8'd0;
        header_done_next = 1'b0;
        resp_done_next   = 1'b0;
        unique case (phase_cur)
            hrhp_pkg::PH_HEADER: begin
                if (in_byte_reg == hrhp_pkg::CH_CR) begin
                    term_next = (term_cur == hrhp_pkg::TM_CRLF) ? hrhp_pkg::TM_CRLFCR
                                                                : hrhp_pkg::TM_CR;
                end else if ((in_byte_reg == hrhp_pkg::CH_LF)
                             && (term_cur == hrhp_pkg::TM_CR)) begin
                    term_next = hrhp_pkg::TM_CRLF;
                end else begin
                    term_next = hrhp_pkg::TM_NONE;
                end
                if (hcnt_cur != hrhp_pkg::HDR_COUNT_MAX) begin
                    hcnt_next = hcnt_cur + 16'd1;
                end
                if (complete) begin
                    priority if (st_flags.bad) begin
                        err_next = hrhp_pkg::ERR_BAD_STATUS;
                    end else if (st_flags.not_200) begin
                        err_next = hrhp_pkg::ERR_NOT_200;
                    end else if (!len_flags.found) begin
                        err_next = hrhp_pkg::ERR_NO_LENGTH;
                    end else if (len_flags.bad) begin
                        err_next = hrhp_pkg::ERR_BAD_LENGTH;
                    end else begin
                        err_next = hrhp_pkg::ERR_NONE;
                    end
                    if (err_next != hrhp_pkg::ERR_NONE) begin
                        phase_next = hrhp_pkg::PH_ERROR;
                    end else begin
                        header_done_next = 1'b1;
                        body_cnt_next    = '0;
                        if (len_value == '0) begin
                            resp_done_next = 1'b1;
                            phase_next     = hrhp_pkg::PH_DONE;
                        end else begin
                            phase_next = hrhp_pkg::PH_BODY;
                        end
                    end
                end else if (hcnt_next >= hdr_limit_reg) begin
                    err_next   = hrhp_pkg::ERR_HDR_LONG;
                    phase_next = hrhp_pkg::PH_ERROR;
                end
            end
            hrhp_pkg::PH_BODY: begin
                body_valid_next = 1'b1;
                body_byte_next  = in_byte_reg;
                body_cnt_next   = body_cnt_inc;
                if (body_cnt_inc >= len_value) begin
                    resp_done_next = 1'b1;
                    phase_next     = hrhp_pkg::PH_DONE;
                end
            end
            default: begin
                // done or error: drop the byte
            end
        endcase
    end

    assign body_len_next = ((phase_next == hrhp_pkg::PH_BODY)
                            || (phase_next == hrhp_pkg::PH_DONE))
                         ? hrhp_pkg::BODY_LEN_W'(len_value) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= hrhp_pkg::PH_HEADER;
            term_reg     <= hrhp_pkg::TM_NONE;
            hcnt_reg     <= 16'd0;
            body_cnt_reg <= '0;
        end else if (adv) begin
            phase_reg    <= phase_next;
            term_reg     <= term_next;
            hcnt_reg     <= hcnt_next;
            body_cnt_reg <= body_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            body_valid_reg  <= body_valid_next;
            body_byte_reg   <= body_byte_next;
            header_done_reg <= header_done_next;
            resp_done_reg   <= resp_done_next;
            err_reg         <= err_next;
            body_len_reg    <= body_len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, body_len_reg, body_byte_reg};
    assign m_tuser  = {err_reg, header_done_reg, body_valid_reg};
    assign m_tlast  = resp_done_reg;

    // a stalled input stage keeps its byte
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_byte_reg)
                                 && $stable(in_first_reg))
        else $error("input stage lost a waiting byte");

    // parse state only moves when an item advances
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(phase_reg) && $stable(hcnt_reg) && $stable(body_cnt_reg))
        else $error("parse state changed without an item");

    // a completed header never carries an error or a body byte
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && header_done_reg |-> (err_reg == hrhp_pkg::ERR_NONE)
                                             && !body_valid_reg)
        else $error("header done together with error or body byte");

    // response done without a body byte only on a zero-length header
    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && resp_done_reg && !body_valid_reg |-> header_done_reg
                                                            && (body_len_reg == '0))
        else $error("response done without body byte outside zero length");

endmodule

FILE: dv/http_response_header_parser_top_tb.sv
`timescale 1ns / 1ps

module http_response_header_parser_top_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TARGET_BYTES = 1050;
    localparam logic [63:0] LEN_CEIL = (64'd1 << hrhp_pkg::COUNT_BITS_DEF) - 64'd2;

    typedef struct packed {
        logic           body_valid;
        logic [7:0]     body_byte;
        logic           header_done;
        logic           response_done;
        hrhp_pkg::err_t error_code;
        logic [30:0]    content_len;
    } parse_beat_t;

    // Tracks the parse of the response stream and holds the beats still owed by the block.
    class response_tracker;
        logic [15:0]             hdr_limit = hrhp_pkg::HDR_LIMIT_RST;
        hrhp_pkg::phase_t        phase;
        logic [15:0]             hdr_count;
        hrhp_pkg::status_state_t st;
        logic [9:0]              status;
        logic [3:0]              kw_idx;
        hrhp_pkg::len_state_t    ls;
        logic [30:0]             len;
        logic [1:0]              term;
        logic [30:0]             body_count;
        string                   keyword = "Content-Length";
        parse_beat_t             beats[$];
        int                      errors = 0;
        int                      checked = 0;

        function void restart();
            phase      = hrhp_pkg::PH_HEADER;
            hdr_count  = '0;
            st         = hrhp_pkg::ST_BEFORE;
            status     = '0;
            kw_idx     = '0;
            ls         = hrhp_pkg::LS_SEARCH;
            len        = '0;
            term       = hrhp_pkg::TM_NONE;
            body_count = '0;
        endfunction

        function void set_limit(logic [15:0] v);
            hdr_limit = v;
        endfunction

        function bit dec_digit(logic [7:0] b);
            return (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);
        endfunction

        function void add_status_digit(logic [7:0] b);
            int v;
            v = status * 10 + b - hrhp_pkg::CH_ZERO;
            status = (v > hrhp_pkg::STATUS_SAT) ? hrhp_pkg::STATUS_SAT : v[9:0];
        endfunction

        function void step_status(logic [7:0] b, logic crlf);
            logic blank;
            blank = (b == hrhp_pkg::CH_SP) || (b == hrhp_pkg::CH_TAB);
            case (st)
                hrhp_pkg::ST_BEFORE: begin
                    if (crlf) st = hrhp_pkg::ST_BAD;
                    else if (b == hrhp_pkg::CH_SP) st = hrhp_pkg::ST_AFTER_SP;
                end
                hrhp_pkg::ST_AFTER_SP: begin
                    if (b == hrhp_pkg::CH_CR) st = hrhp_pkg::ST_SP_CR;
                    else if (blank) st = hrhp_pkg::ST_SKIP;
                    else if (dec_digit(b)) begin
                        status = '0;
                        add_status_digit(b);
                        st = hrhp_pkg::ST_DIGITS;
                    end else st = hrhp_pkg::ST_FINISHED;
                end
                hrhp_pkg::ST_SP_CR:
                    st = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_BAD : hrhp_pkg::ST_FINISHED;
                hrhp_pkg::ST_SKIP: begin
                    if (dec_digit(b)) begin
                        status = '0;
                        add_status_digit(b);
                        st = hrhp_pkg::ST_DIGITS;
                    end else if (!blank) st = hrhp_pkg::ST_FINISHED;
                end
                hrhp_pkg::ST_DIGITS: begin
                    if (dec_digit(b)) add_status_digit(b);
                    else st = hrhp_pkg::ST_FINISHED;
                end
                default: ;
            endcase
        endfunction

        function void step_length(logic [7:0] b);
            logic [63:0] v;
            case (ls)
                hrhp_pkg::LS_SEARCH: begin
                    if (kw_idx < hrhp_pkg::KW_LEN && b == keyword[kw_idx]) begin
                        kw_idx++;
                        if (kw_idx >= hrhp_pkg::KW_LEN) ls = hrhp_pkg::LS_SKIP;
                    end else begin
                        // restart the match, counting this byte if it opens the keyword
                        kw_idx = (b == keyword[0]) ? 4'd1 : 4'd0;
                    end
                end
                hrhp_pkg::LS_SKIP: begin
                    if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_COLON
                        || b == hrhp_pkg::CH_TAB) ;
                    else if (b == hrhp_pkg::CH_MINUS) ls = hrhp_pkg::LS_BAD;
                    else if (dec_digit(b)) begin
                        len = 31'(b - hrhp_pkg::CH_ZERO);
                        ls = hrhp_pkg::LS_DIGITS;
                    end else begin
                        len = '0;
                        ls = hrhp_pkg::LS_DONE;
                    end
                end
                hrhp_pkg::LS_DIGITS: begin
                    if (dec_digit(b)) begin
                        v = {33'd0, len} * 64'd10 + 64'(b - hrhp_pkg::CH_ZERO);
                        if (v > LEN_CEIL) ls = hrhp_pkg::LS_BAD;
                        else len = v[30:0];
                    end else ls = hrhp_pkg::LS_DONE;
                end
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic first);
            parse_beat_t r;
            logic crlf, complete;
            if (first) restart();
            r = '0;
            r.error_code = hrhp_pkg::ERR_NONE;
            if (phase == hrhp_pkg::PH_HEADER) begin
                crlf = (b == hrhp_pkg::CH_LF)
                    && (term == hrhp_pkg::TM_CR || term == hrhp_pkg::TM_CRLFCR);
                complete = (b == hrhp_pkg::CH_LF) && (term == hrhp_pkg::TM_CRLFCR);
                if (b == hrhp_pkg::CH_CR)
                    term = (term == hrhp_pkg::TM_CRLF) ? hrhp_pkg::TM_CRLFCR : hrhp_pkg::TM_CR;
                else if (b == hrhp_pkg::CH_LF && term == hrhp_pkg::TM_CR)
                    term = hrhp_pkg::TM_CRLF;
                else term = hrhp_pkg::TM_NONE;
                if (hdr_count != hrhp_pkg::HDR_COUNT_MAX) hdr_count++;
                step_status(b, crlf);
                step_length(b);
                if (complete) begin
                    // status problems win over length problems
                    if (st != hrhp_pkg::ST_DIGITS && st != hrhp_pkg::ST_FINISHED)
                        r.error_code = hrhp_pkg::ERR_BAD_STATUS;
                    else if (status != hrhp_pkg::STATUS_OK)
                        r.error_code = hrhp_pkg::ERR_NOT_200;
                    else if (ls == hrhp_pkg::LS_SEARCH)
                        r.error_code = hrhp_pkg::ERR_NO_LENGTH;
                    else if (ls == hrhp_pkg::LS_BAD)
                        r.error_code = hrhp_pkg::ERR_BAD_LENGTH;
                    if (r.error_code != hrhp_pkg::ERR_NONE) phase = hrhp_pkg::PH_ERROR;
                    else begin
                        r.header_done = 1'b1;
                        body_count = '0;
                        if (len == '0) begin
                            r.response_done = 1'b1;
                            phase = hrhp_pkg::PH_DONE;
                        end else phase = hrhp_pkg::PH_BODY;
                    end
                end else if (hdr_count >= hdr_limit) begin
                    r.error_code = hrhp_pkg::ERR_HDR_LONG;
                    phase = hrhp_pkg::PH_ERROR;
                end
            end else if (phase == hrhp_pkg::PH_BODY) begin
                r.body_valid = 1'b1;
                r.body_byte = b;
                body_count++;
                if (body_count >= len) begin
                    r.response_done = 1'b1;
                    phase = hrhp_pkg::PH_DONE;
                end
            end
            r.content_len = (phase == hrhp_pkg::PH_BODY || phase == hrhp_pkg::PH_DONE)
                          ? len : '0;
            beats.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s: got %0h, want %0h", checked, name, got, want));
        endtask

        task compare_beat(logic [39:0] tdata, logic [4:0] tuser, logic tlast);
            parse_beat_t w;
            if (beats.size() == 0) begin
                report($sformatf("result with nothing pending: tdata=%h tuser=%h tlast=%b",
                                 tdata, tuser, tlast));
                return;
            end
            w = beats.pop_front();
            check_field("body_valid", 32'(tuser[0]), 32'(w.body_valid));
            check_field("body_byte", 32'(tdata[7:0]), 32'(w.body_byte));
            check_field("header_done", 32'(tuser[1]), 32'(w.header_done));
            check_field("response_done", 32'(tlast), 32'(w.response_done));
            check_field("error_code", 32'(tuser[4:2]), 32'(w.error_code));
            check_field("content_len", 32'(tdata[38:8]), 32'(w.content_len));
            check_field("tdata pad", 32'(tdata[39]), 32'd0);
            checked++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    response_tracker trk = new;
    logic [8:0]      stream_q[$];   // [8] extra first-byte mark, [7:0] byte
    int              sent_count = 0;
    bit              calm_tx = 1'b0;
    bit              calm_rx = 1'b0;

    http_response_header_parser_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task put(string s);
        int i;
        for (i = 0; i < s.len(); i++) stream_q.push_back({1'b0, s[i]});
    endtask

    task put_raw(logic [7:0] b);
        stream_q.push_back({1'b0, b});
    endtask

    task put_line(string s);
        put(s);
        put_raw(hrhp_pkg::CH_CR);
        put_raw(hrhp_pkg::CH_LF);
    endtask

    task put_body(int n);
        int i;
        for (i = 0; i < n; i++) put_raw(8'($urandom));
    endtask

    task send_byte(logic [7:0] b, logic first);
        int gap;
        if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
        gap = calm_tx ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        trk.take_byte(b, first);
        sent_count++;
    endtask

    task send_stream();
        int i;
        for (i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i][7:0], (i == 0) || stream_q[i][8]);
        stream_q.delete();
    endtask

    // hold the input off until every owed beat has come out
    task drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (trk.beats.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task write_limit(logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        trk.set_limit(v);
    endtask

    task run_directed();
        // good response, extreme body bytes, trailing bytes dropped after done
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Length: 5");
        put_line("");
        put_raw(8'h00); put_raw(8'hFF); put_raw(8'h80); put_raw(8'h7F);
        put_raw(hrhp_pkg::CH_LF);
        put_raw(8'h55); put_raw(8'hAA);
        send_stream();
        // blanks before the code, zero length finishes with the header
        put_line("HTTP/1.1 \t 200 OK");
        put_line("Content-Length:0");
        put_line("");
        put_raw(8'h31);
        send_stream();
        // space right before the first CRLF
        put_line("HTTP/1.1 ");
        put_line("Content-Length: 3");
        put_line("");
        send_stream();
        // no space in the status line
        put_line("HTTP/1.1");
        put_line("Content-Length: 1");
        put_line("");
        send_stream();
        // no digits, saturating code, plain wrong code
        put_line("HTTP/1.1 OK");
        put_line("Content-Length: 1");
        put_line("");
        send_stream();
        put_line("HTTP/1.1 99999 OK");
        put_line("Content-Length: 1");
        put_line("");
        send_stream();
        put_line("HTTP/1.1 404 Not Found");
        put_line("Content-Length: 2");
        put_line("");
        send_stream();
        // keyword match is case sensitive
        put_line("HTTP/1.1 200 OK");
        put_line("content-length: 4");
        put_line("");
        send_stream();
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Length: -4");
        put_line("");
        send_stream();
        // no digits after the keyword means length zero
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Length:");
        put_line("");
        send_stream();
        // largest legal length, cut short by the next response
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Length: 2147483646");
        put_line("");
        put_body(3);
        send_stream();
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Length: 2147483647");
        put_line("");
        send_stream();
        // bad status and bad length together
        put_line("HTTP/1.1");
        put_line("Content-Length: -1");
        put_line("");
        send_stream();
        put_line("HTTP/1.1 200 OK");
        put_line("Content-Content-Length: \t2");
        put_line("");
        put_body(2);
        send_stream();
        // first length wins, NUL inside a header line
        put_line("HTTP/1.1 200 OK");
        put("X-Nul: ");
        put_raw(8'h00);
        put_line("");
        put_line("Content-Length: 2");
        put_line("Content-Length: 9");
        put_line("");
        put_body(2);
        send_stream();
        put("HTTP/1.1 200 OK");
        send_stream();
        // code ends right at the CRLF
        put_line("HTTP/1.0 200");
        put_line("Content-Length: 12");
        put_line("");
        put_body(12);
        send_stream();
    endtask

    task put_length_field(output int body_n);
        int pick;
        logic [31:0] lenv;
        body_n = $urandom_range(0, 4);
        pick = $urandom_range(0, 19);
        if (pick == 0) return;
        if (pick == 1) begin
            put_line("content-length: 3");
            return;
        end
        put("Content-Length");
        case ($urandom_range(0, 4))
            0: put(": ");
            1: put(":");
            2: put(":\t");
            3: put(" : ");
            default: put(":  ");
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            put("-");
            put($sformatf("%0d", $urandom_range(0, 99)));
        end else if (pick == 1) begin
            if ($urandom_range(0, 1)) put("2147483647");
            else put("99999999999");
        end else if (pick == 2) begin
            body_n = 0;
        end else if (pick == 3) begin
            lenv = $urandom_range(41, 2147483646);
            put($sformatf("%0d", lenv));
            body_n = $urandom_range(0, 20);
        end else begin
            lenv = $urandom_range(0, 40);
            put($sformatf("%0d", lenv));
            body_n = int'(lenv);
            case ($urandom_range(0, 9))
                0: body_n = $urandom_range(0, body_n);
                1: body_n = body_n + $urandom_range(1, 3);
                default: ;
            endcase
        end
        put_line("");
    endtask

    task build_random();
        int i, j, n, m, cl_at, sp, body_n;
        stream_q.delete();
        if ($urandom_range(0, 99) < 12) begin
            // noise, with an occasional restart in the middle
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
                stream_q.push_back({$urandom_range(0, 15) == 0, 8'($urandom)});
            return;
        end
        put("HTTP/1.1");
        sp = $urandom_range(0, 19);
        if (sp == 0) put_line("");
        else if (sp == 1) put_line(" ");
        else begin
            if (sp == 2) put(" \t ");
            else put(" ");
            case ($urandom_range(0, 9))
                7: put($sformatf("%0d", $urandom_range(0, 999)));
                8: put("20000");
                9: ;
                default: put("200");
            endcase
            put_line(" OK");
        end
        body_n = 0;
        n = $urandom_range(0, 3);
        cl_at = $urandom_range(0, n);
        for (i = 0; i <= n; i++) begin
            if (i == cl_at) put_length_field(body_n);
            if (i < n) begin
                put("X-Tag: ");
                m = $urandom_range(0, 8);
                for (j = 0; j < m; j++)
                    put_raw(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(33, 126)));
                put_line("");
            end
        end
        put_line("");
        put_body(body_n);
    endtask

    task run_random();
        int setting_no;
        int setting_end;
        setting_no = 0;
        setting_end = sent_count;
        while (sent_count < TARGET_BYTES) begin
            if (sent_count >= setting_end) begin
                setting_no++;
                case (setting_no)
                    1: begin
                        write_limit(16'd16);
                        setting_end = sent_count + 60;
                    end
                    2: begin
                        write_limit(16'hFFFF);
                        setting_end = sent_count + 250;
                    end
                    default: begin
                        write_limit($urandom_range(0, 1) ? 16'($urandom_range(16, 160))
                                                         : 16'($urandom_range(161, 65535)));
                        setting_end = sent_count + 200;
                    end
                endcase
            end else if ($urandom_range(0, 19) == 0) begin
                drain();
            end
            build_random();
            send_stream();
        end
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
            gap = calm_rx ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            trk.compare_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        trk.restart();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (trk.beats.size() != 0);
        repeat (10) @(posedge aclk);
        if (trk.errors == 0 && trk.beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
